>>> rtl/lcdns_pkg.sv
// Package for the character LCD nibble sequencer.
// Holds opcodes, register indexes, job and step types and timing constants.
// No dependencies; every other file of the block imports it.
package lcdns_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned HOLD_W  = 15;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // Timing defaults in microseconds
  localparam int unsigned PULSE_US_DEF     = 200;
  localparam int unsigned LONG_WAIT_US_DEF = 2000;
  localparam int unsigned POWER_UP_US_DEF  = 20000;
  localparam int unsigned SETTLE_US        = 50;
  localparam int unsigned WAKE_FIRST_US    = 5000;
  localparam int unsigned WAKE_SECOND_US   = 100;
  localparam int unsigned HOLD_MAX         = 32767;

  // Step counts and indexes of the init run, and the last cursor row and column
  localparam int unsigned INIT_STEPS     = 25;
  localparam int unsigned WAKE_END_STEP  = 9;
  localparam int unsigned LAST_ROW       = 3;
  localparam int unsigned LAST_COL       = 19;

  // Queue between front and back
  localparam int unsigned QUEUE_AW = 1;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_COMMAND = 2'd1,
    OP_DATA    = 2'd2,
    OP_CURSOR  = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FUNCTION_SET = 3'd0,
    CFG_DISPLAY_CTRL = 3'd1,
    CFG_ENTRY_MODE   = 3'd2,
    CFG_CLEAR        = 3'd3,
    CFG_HOME         = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    JOB_INIT  = 3'b001,
    JOB_BYTE  = 3'b010,
    JOB_ERROR = 3'b100
  } job_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] function_set;
    logic [CODE_W-1:0] display_ctrl;
    logic [CODE_W-1:0] entry_mode;
    logic [CODE_W-1:0] clear;
    logic [CODE_W-1:0] home;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    logic              rs;
    logic [CODE_W-1:0] code;
    logic              long_wait;
  } job_t;

  typedef struct packed {
    logic              reg_select;
    logic [3:0]        nibble;
    logic              enable;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
    logic              error;
  } step_t;

  // DDRAM base address of each display row
  function automatic logic [CODE_W-1:0] row_base(input logic [1:0] row);
    logic [CODE_W-1:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // Clamp a hold time to the width of the hold field
  function automatic logic [HOLD_W-1:0] hold_sat(input int unsigned us);
    logic [HOLD_W-1:0] h;
    if (us > HOLD_MAX) begin
      h = HOLD_W'(HOLD_MAX);
    end else begin
      h = HOLD_W'(us);
    end
    return h;
  endfunction

endpackage

>>> rtl/lcdns_if.sv
// Handshake interfaces of the character LCD nibble sequencer.
// lcdns_req_if carries requests, lcdns_step_if carries pin steps.
// Depends on lcdns_pkg for field widths.
interface lcdns_req_if;
  import lcdns_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [CODE_W-1:0]    value;
  logic [2:0]           row;
  logic [4:0]           col;

  modport source (output valid, opcode, value, row, col, input ready);
  modport sink   (input valid, opcode, value, row, col, output ready);
endinterface

interface lcdns_step_if;
  import lcdns_pkg::*;
  logic              valid;
  logic              ready;
  logic              reg_select;
  logic [3:0]        nibble;
  logic              enable;
  logic [HOLD_W-1:0] hold_us;
  logic              last;
  logic              error;

  modport source (output valid, reg_select, nibble, enable, hold_us, last, error,
                  input ready);
  modport sink   (input valid, reg_select, nibble, enable, hold_us, last, error,
                  output ready);
endinterface

>>> rtl/char_lcd_nibble_sequencer_unit.sv
// Top level of the character LCD nibble sequencer.
// Holds the configuration registers and joins front end, job queue and back end.
// Depends on lcdns_pkg, lcdns_if, lcdns_front, lcdns_queue and lcdns_back.
//
// Usage:
//   req_i is a valid/ready channel of requests: init, command byte, character
//   byte or set cursor (row, col). step_o is a valid/ready channel of pin steps
//   (reg_select, nibble, enable, hold_us) with last on the final step of each
//   request's run and error on the single result of an out-of-range cursor.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the five command codes; write them
//   only while no request is in flight.
// Timing:
//   A request is taken into a two-entry job queue at the edge it is accepted;
//   its first step reaches step_o through the queue and the output step register.
//   Steps leave at one per cycle while step_o is not stalled, limited by
//   the single output step register: an init run has 25 steps, a command,
//   character or cursor request 4, a cursor error 1. Requests are taken
//   while the queue has room, also when step_o is stalled.
// Reset:
//   Clears the queue, the step counter and the output valid, sets the codes
//   to their defaults and the cursor address to zero. When step_o stalls the
//   current step holds and the back end stops; the queue then fills and
//   req_i.ready falls.
module char_lcd_nibble_sequencer_unit #(
  parameter int unsigned PULSE_US     = lcdns_pkg::PULSE_US_DEF,
  parameter int unsigned LONG_WAIT_US = lcdns_pkg::LONG_WAIT_US_DEF,
  parameter int unsigned POWER_UP_US  = lcdns_pkg::POWER_UP_US_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  lcdns_req_if.sink                            req_i,
  lcdns_step_if.source                         step_o,
  input  logic                                 cfg_we_i,
  input  logic [lcdns_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lcdns_pkg::CODE_W-1:0]         cfg_data_i
);
  import lcdns_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic push, pop, full, empty;

  // Write the command code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set <= 8'h28;
      cfg_q.display_ctrl <= 8'h0E;
      cfg_q.entry_mode   <= 8'h06;
      cfg_q.clear        <= 8'h01;
      cfg_q.home         <= 8'h02;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FUNCTION_SET: cfg_q.function_set <= cfg_data_i;
        CFG_DISPLAY_CTRL: cfg_q.display_ctrl <= cfg_data_i;
        CFG_ENTRY_MODE:   cfg_q.entry_mode   <= cfg_data_i;
        CFG_CLEAR:        cfg_q.clear        <= cfg_data_i;
        CFG_HOME:         cfg_q.home         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lcdns_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  lcdns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .job_o   (head_job)
  );

  lcdns_back #(
    .PULSE_US     (PULSE_US),
    .LONG_WAIT_US (LONG_WAIT_US),
    .POWER_UP_US  (POWER_UP_US)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (head_job),
    .pop_o   (pop),
    .step    (step_o)
  );

endmodule

>>> rtl/lcdns_front.sv
// Front end: accepts requests, classifies them into jobs, tracks the cursor.
// Pushes one job per accepted word into the job queue.
// Depends on lcdns_pkg and lcdns_req_if.
module lcdns_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcdns_req_if.sink         req,
  input  lcdns_pkg::cfg_t   cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output lcdns_pkg::job_t   job_o
);
  import lcdns_pkg::*;

  logic [CODE_W-1:0] cursor_q, cursor_d;
  logic [CODE_W-1:0] ddram_cmd;
  logic              in_range;
  logic              accept;

  assign req.ready = !full_i;
  assign accept    = req.valid && !full_i;
  assign push_o    = accept;

  // Work out the set-address command and range check
  assign in_range  = (req.row <= 3'(LAST_ROW)) && (req.col <= 5'(LAST_COL));
  assign ddram_cmd = 8'h80 | (CODE_W'(req.col) + row_base(req.row[1:0]));

  // Classify the request
  always_comb begin
    job_o.kind      = JOB_BYTE;
    job_o.rs        = 1'b0;
    job_o.code      = req.value;
    job_o.long_wait = 1'b0;
    cursor_d        = cursor_q;
    case (opcode_e'(req.opcode))
      OP_INIT: begin
        job_o.kind = JOB_INIT;
      end
      OP_COMMAND: begin
        job_o.long_wait = (req.value == cfg_i.clear) || (req.value == cfg_i.home);
      end
      OP_DATA: begin
        job_o.rs = 1'b1;
      end
      OP_CURSOR: begin
        if (in_range) begin
          job_o.code = ddram_cmd;
          cursor_d   = ddram_cmd;
        end else begin
          job_o.kind = JOB_ERROR;
        end
      end
      default: begin
        job_o.kind = JOB_ERROR;
      end
    endcase
  end

  // Hold the last address command sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (accept) begin
      cursor_q <= cursor_d;
    end
  end

endmodule

>>> rtl/lcdns_queue.sv
// Short job queue between front and back end.
// Register-based FIFO of 2**QUEUE_AW entries; depends on lcdns_pkg.
module lcdns_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdns_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output lcdns_pkg::job_t job_o
);
  import lcdns_pkg::*;

  localparam int unsigned DEPTH = 2 ** QUEUE_AW;

  job_t                mem_q [DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store job payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> rtl/lcdns_back.sv
// Back end: plays the head job of the queue as a run of timed pin steps.
// One step per unstalled cycle, registered; depends on lcdns_pkg, lcdns_step_if.
module lcdns_back #(
  parameter int unsigned PULSE_US     = lcdns_pkg::PULSE_US_DEF,
  parameter int unsigned LONG_WAIT_US = lcdns_pkg::LONG_WAIT_US_DEF,
  parameter int unsigned POWER_UP_US  = lcdns_pkg::POWER_UP_US_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lcdns_pkg::cfg_t cfg_i,
  input  logic            empty_i,
  input  lcdns_pkg::job_t job_i,
  output logic            pop_o,
  lcdns_step_if.source    step
);
  import lcdns_pkg::*;

  localparam logic [HOLD_W-1:0] PulseHold  = hold_sat(PULSE_US);
  localparam logic [HOLD_W-1:0] LongHold   = hold_sat(LONG_WAIT_US);
  localparam logic [HOLD_W-1:0] PowerHold  = hold_sat(POWER_UP_US);
  localparam logic [HOLD_W-1:0] SettleHold = hold_sat(SETTLE_US);
  localparam logic [HOLD_W-1:0] WakeHold1  = hold_sat(WAKE_FIRST_US);
  localparam logic [HOLD_W-1:0] WakeHold2  = hold_sat(WAKE_SECOND_US);

  logic [STEP_W-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  step_t             out_q, out_d;
  step_t             cur;
  logic              advance;
  logic [STEP_W-1:0] wake_idx, cmd_idx;
  logic [1:0]        sub;
  logic [CODE_W-1:0] code;
  logic              long_wait;
  logic [CODE_W-1:0] init_code;
  logic              use_byte;

  assign advance = !out_valid_q || step.ready;

  assign wake_idx = count_q - STEP_W'(1);
  assign cmd_idx  = count_q - STEP_W'(WAKE_END_STEP);

  // Pick the init command for this position
  always_comb begin
    case (cmd_idx[3:2])
      2'd0:    init_code = cfg_i.function_set;
      2'd1:    init_code = cfg_i.display_ctrl;
      2'd2:    init_code = cfg_i.entry_mode;
      2'd3:    init_code = cfg_i.clear;
      default: init_code = cfg_i.clear;
    endcase
  end

  // Build the step for the head job
  always_comb begin
    cur       = '0;
    use_byte  = 1'b0;
    sub       = count_q[1:0];
    code      = job_i.code;
    long_wait = job_i.long_wait;
    case (job_i.kind)
      JOB_BYTE: begin
        use_byte = 1'b1;
        cur.last = (count_q[1:0] == 2'd3);
      end
      JOB_INIT: begin
        cur.last = (count_q == STEP_W'(INIT_STEPS - 1));
        if (count_q == '0) begin
          cur.hold_us = PowerHold;
        end else if (count_q < STEP_W'(WAKE_END_STEP)) begin
          // Wake-up nibbles 3, 3, 3, 2
          cur.nibble = (wake_idx[2:1] == 2'd3) ? 4'h2 : 4'h3;
          cur.enable = !wake_idx[0];
          if (!wake_idx[0]) begin
            cur.hold_us = PulseHold;
          end else begin
            case (wake_idx[2:1])
              2'd0:    cur.hold_us = WakeHold1;
              2'd1:    cur.hold_us = WakeHold2;
              default: cur.hold_us = '0;
            endcase
          end
        end else begin
          use_byte  = 1'b1;
          sub       = cmd_idx[1:0];
          code      = init_code;
          long_wait = (init_code == cfg_i.clear) || (init_code == cfg_i.home);
        end
      end
      JOB_ERROR: begin
        cur.last  = 1'b1;
        cur.error = 1'b1;
      end
      default: begin
        cur.last  = 1'b1;
        cur.error = 1'b1;
      end
    endcase
    // Byte as high then low nibble, each pulse then gap
    if (use_byte) begin
      cur.reg_select = job_i.rs;
      cur.nibble     = sub[1] ? code[3:0] : code[7:4];
      cur.enable     = !sub[0];
      if (!sub[0]) begin
        cur.hold_us = PulseHold;
      end else if (sub[1]) begin
        cur.hold_us = long_wait ? LongHold : SettleHold;
      end else begin
        cur.hold_us = '0;
      end
    end
  end

  // Advance through the run while the output register can take a step
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d = cur;
        if (cur.last) begin
          count_d = '0;
          pop_o   = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Drive the step channel
  assign step.valid      = out_valid_q;
  assign step.reg_select = out_q.reg_select;
  assign step.nibble     = out_q.nibble;
  assign step.enable     = out_q.enable;
  assign step.hold_us    = out_q.hold_us;
  assign step.last       = out_q.last;
  assign step.error      = out_q.error;

endmodule

>>> rtl/lcdns_checker.sv
// Port-level checks for the character LCD nibble sequencer.
// Bound to char_lcd_nibble_sequencer_unit; depends on lcdns_pkg for widths.
module lcdns_checker #(
  parameter int unsigned PULSE_US = lcdns_pkg::PULSE_US_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          ready_i,
  input logic                          reg_select_i,
  input logic [3:0]                    nibble_i,
  input logic                          enable_i,
  input logic [lcdns_pkg::HOLD_W-1:0]  hold_us_i,
  input logic                          last_i,
  input logic                          error_i
);
  import lcdns_pkg::*;

  // Error result drives no pins and ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && error_i |-> last_i && !enable_i && !reg_select_i && nibble_i == 4'h0
                           && hold_us_i == '0)
    else $error("cursor error step is not a bare final step");

  // Enable pulse always lasts the pulse time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && enable_i |-> hold_us_i == hold_sat(PULSE_US) && !error_i)
    else $error("enable pulse with wrong hold time");

  // A run never ends on an enable pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && enable_i |-> !last_i)
    else $error("run ends with enable high");

  // Stalled step holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(nibble_i) && $stable(hold_us_i)
                            && $stable(last_i) && $stable(enable_i))
    else $error("stalled step changed");

endmodule

bind char_lcd_nibble_sequencer_unit lcdns_checker #(
  .PULSE_US (PULSE_US)
) u_lcdns_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (step_o.valid),
  .ready_i      (step_o.ready),
  .reg_select_i (step_o.reg_select),
  .nibble_i     (step_o.nibble),
  .enable_i     (step_o.enable),
  .hold_us_i    (step_o.hold_us),
  .last_i       (step_o.last),
  .error_i      (step_o.error)
);

>>> tb/sv/tb.sv
// Self-checking bench for char_lcd_nibble_sequencer_unit: a directed opening table,
// then randomised requests over several code settings, checked against a pin-step predictor.
// Depends on lcdns_pkg, lcdns_if and the RTL of the sequencer.
module tb;
  import lcdns_pkg::*;

  localparam int unsigned PULSE_US     = PULSE_US_DEF;
  localparam int unsigned LONG_WAIT_US = LONG_WAIT_US_DEF;
  localparam int unsigned POWER_UP_US  = POWER_UP_US_DEF;
  localparam logic [7:0]  DDRAM_SET    = 8'h80;
  localparam int unsigned ITEMS_PER_SETTING = 60;
  localparam int unsigned SETTLE_CYCLES     = 8;
  localparam int unsigned STALL_LIMIT       = 1500;
  localparam int unsigned REPORT_LIMIT      = 10;
  localparam int unsigned OPENING_ROWS      = 20;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] value;
    logic [2:0] row;
    logic [4:0] col;
  } lcd_req_t;

  typedef struct packed {
    lcd_req_t req;
    logic     typed;
    step_t    want;
  } stim_row_t;

  localparam step_t CURSOR_FAULT = '{reg_select: 1'b0, nibble: 4'h0, enable: 1'b0,
                                     hold_us: '0, last: 1'b1, error: 1'b1};
  localparam step_t NO_STEP = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CODE_W-1:0] cfg_data;

  lcdns_req_if  req_ch();
  lcdns_step_if step_ch();

  char_lcd_nibble_sequencer_unit #(
    .PULSE_US     (PULSE_US),
    .LONG_WAIT_US (LONG_WAIT_US),
    .POWER_UP_US  (POWER_UP_US)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .step_o     (step_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: command codes, last cursor address, pin steps still due
  cfg_t        codes;
  logic [7:0]  cursor_addr;
  step_t       steps_due[$];
  logic [7:0]  row_start [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;

  // Idle bursts for each side
  bit          send_calm;
  int unsigned send_calm_left;
  bit          take_calm;
  int unsigned take_calm_left;

  stim_row_t opening_rows [OPENING_ROWS] = '{
    '{'{OP_INIT,    8'h00, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_COMMAND, 8'h00, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_COMMAND, 8'hFF, 3'd7, 5'd31}, 1'b0, NO_STEP},
    '{'{OP_COMMAND, 8'h01, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_COMMAND, 8'h02, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_COMMAND, 8'h80, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_DATA,    8'h00, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_DATA,    8'hFF, 3'd7, 5'd31}, 1'b0, NO_STEP},
    '{'{OP_DATA,    8'h01, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_DATA,    8'h02, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_DATA,    8'h5A, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_CURSOR,  8'h00, 3'd0, 5'd0},  1'b0, NO_STEP},
    '{'{OP_CURSOR,  8'hFF, 3'd3, 5'd19}, 1'b0, NO_STEP},
    '{'{OP_CURSOR,  8'h00, 3'd1, 5'd7},  1'b0, NO_STEP},
    '{'{OP_CURSOR,  8'h00, 3'd2, 5'd12}, 1'b0, NO_STEP},
    '{'{OP_CURSOR,  8'h00, 3'd4, 5'd0},  1'b1, CURSOR_FAULT},
    '{'{OP_CURSOR,  8'hFF, 3'd7, 5'd31}, 1'b1, CURSOR_FAULT},
    '{'{OP_CURSOR,  8'h00, 3'd0, 5'd20}, 1'b1, CURSOR_FAULT},
    '{'{OP_CURSOR,  8'h00, 3'd3, 5'd20}, 1'b1, CURSOR_FAULT},
    '{'{OP_INIT,    8'hFF, 3'd7, 5'd31}, 1'b0, NO_STEP}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Draw a wait, with runs of back-to-back words between idle stretches
  function automatic int unsigned draw_wait(inout bit calm, inout int unsigned calm_left);
    if (calm_left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      calm_left = $urandom_range(4, 24);
    end
    calm_left--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Predictor: one pin step, hold clamped to the field
  function automatic void add_step(logic rs, logic [3:0] nib, logic en, int unsigned us);
    step_t s;
    s.reg_select = rs;
    s.nibble = nib;
    s.enable = en;
    s.hold_us = (us > HOLD_MAX) ? HOLD_W'(HOLD_MAX) : HOLD_W'(us);
    s.last = 1'b0;
    s.error = 1'b0;
    steps_due.push_back(s);
  endfunction

  // Enable pulse, then enable low for the given gap
  function automatic void add_nibble(logic rs, logic [3:0] nib, int unsigned after_us);
    add_step(rs, nib, 1'b1, PULSE_US);
    add_step(rs, nib, 1'b0, after_us);
  endfunction

  // High nibble with no gap, low nibble with the settle time
  function automatic void add_byte(logic rs, logic [7:0] b, int unsigned settle_us);
    add_nibble(rs, b[7:4], 0);
    add_nibble(rs, b[3:0], settle_us);
  endfunction

  function automatic void add_command(logic [7:0] b);
    add_byte(1'b0, b, (b == codes.clear || b == codes.home) ? LONG_WAIT_US : SETTLE_US);
  endfunction

  // Work out the whole run of pin steps for one accepted request
  function automatic void plan_steps(lcd_req_t r);
    step_t tail;
    bit    fault;
    fault = 1'b0;
    case (r.op)
      OP_INIT: begin
        add_step(1'b0, 4'h0, 1'b0, POWER_UP_US);
        add_nibble(1'b0, 4'h3, WAKE_FIRST_US);
        add_nibble(1'b0, 4'h3, WAKE_SECOND_US);
        add_nibble(1'b0, 4'h3, 0);
        add_nibble(1'b0, 4'h2, 0);
        add_command(codes.function_set);
        add_command(codes.display_ctrl);
        add_command(codes.entry_mode);
        add_command(codes.clear);
      end
      OP_COMMAND: begin
        add_command(r.value);
      end
      OP_DATA: begin
        add_byte(1'b1, r.value, SETTLE_US);
      end
      default: begin
        if (r.row > LAST_ROW || r.col > LAST_COL) begin
          add_step(1'b0, 4'h0, 1'b0, 0);
          fault = 1'b1;
        end else begin
          cursor_addr = DDRAM_SET | ({3'b000, r.col} + row_start[r.row[1:0]]);
          add_byte(1'b0, cursor_addr, SETTLE_US);
        end
      end
    endcase
    // Mark the final step of the run
    tail = steps_due.pop_back();
    tail.last = 1'b1;
    tail.error = fault;
    steps_due.push_back(tail);
  endfunction

  // Random request; mostly in-range cursors, commands often hit the long-wait codes
  function automatic lcd_req_t random_request();
    lcd_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      r.op = OP_INIT;
    end else if (pick <= 3) begin
      r.op = OP_COMMAND;
    end else if (pick <= 6) begin
      r.op = OP_DATA;
    end else begin
      r.op = OP_CURSOR;
    end
    r.value = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      r.value = codes.clear;
    end else if (pick == 1) begin
      r.value = codes.home;
    end
    if ($urandom_range(0, 3) != 0) begin
      r.row = 3'($urandom_range(0, LAST_ROW));
      r.col = 5'($urandom_range(0, LAST_COL));
    end else begin
      r.row = 3'($urandom_range(0, 7));
      r.col = 5'($urandom_range(0, 31));
    end
    return r;
  endfunction

  // Offer one request and wait for the handshake; typed rows carry their own step
  task automatic send_request(input lcd_req_t r, input logic typed, input step_t want);
    int unsigned gap;
    gap = draw_wait(send_calm, send_calm_left);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= r.op;
    req_ch.value  <= r.value;
    req_ch.row    <= r.row;
    req_ch.col    <= r.col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (typed) begin
      steps_due.push_back(want);
    end else begin
      plan_steps(r);
    end
  endtask

  // Drop valid and wait until every step due has come out
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Write all five codes back to back, then drop the write enable
  task automatic load_codes(input cfg_t c);
    put_reg(CFG_FUNCTION_SET, c.function_set);
    put_reg(CFG_DISPLAY_CTRL, c.display_ctrl);
    put_reg(CFG_ENTRY_MODE, c.entry_mode);
    put_reg(CFG_CLEAR, c.clear);
    put_reg(CFG_HOME, c.home);
    cfg_we <= 1'b0;
    codes = c;
  endtask

  // Step receiver: stall at random before each word
  initial begin : take_steps
    int unsigned stall;
    step_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(take_calm, take_calm_left);
      if (stall != 0) begin
        step_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      step_ch.ready <= 1'b1;
      @(posedge clk);
      while (!step_ch.valid) @(posedge clk);
    end
  end

  // Check each accepted step against the oldest one due
  always @(posedge clk) begin : check_steps
    step_t got;
    step_t want;
    if (rst_n && step_ch.valid && step_ch.ready) begin
      got = '{reg_select: step_ch.reg_select, nibble: step_ch.nibble,
              enable: step_ch.enable, hold_us: step_ch.hold_us,
              last: step_ch.last, error: step_ch.error};
      if (steps_due.size() == 0) begin
        if (fault_count < REPORT_LIMIT) begin
          $display("unexpected step: rs=%0d nib=%h en=%0d hold=%0d last=%0d err=%0d",
                   got.reg_select, got.nibble, got.enable, got.hold_us, got.last,
                   got.error);
        end
        fault_count++;
      end else begin
        want = steps_due.pop_front();
        if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
            got.enable !== want.enable || got.hold_us !== want.hold_us ||
            got.last !== want.last || got.error !== want.error) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("step mismatch: want rs=%0d nib=%h en=%0d hold=%0d last=%0d err=%0d",
                     want.reg_select, want.nibble, want.enable, want.hold_us, want.last,
                     want.error);
            $display("               got  rs=%0d nib=%h en=%0d hold=%0d last=%0d err=%0d",
                     got.reg_select, got.nibble, got.enable, got.hold_us, got.last,
                     got.error);
          end
          fault_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence: reset, opening table, then random phases over code settings
  initial begin : run_sequence
    cfg_t settings [4];
    settings[0] = '{function_set: 8'h00, display_ctrl: 8'h00, entry_mode: 8'h00,
                    clear: 8'h00, home: 8'h00};
    settings[1] = '{function_set: 8'hFF, display_ctrl: 8'hFF, entry_mode: 8'hFF,
                    clear: 8'hFF, home: 8'hFF};
    settings[2] = cfg_t'({$urandom(), $urandom()});
    settings[3] = '{function_set: 8'h28, display_ctrl: 8'h0E, entry_mode: 8'h06,
                    clear: 8'h01, home: 8'h02};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.value = '0;
    req_ch.row = '0;
    req_ch.col = '0;
    send_calm = 1'b0;
    send_calm_left = 0;
    take_calm = 1'b0;
    take_calm_left = 0;
    codes = '{function_set: 8'h28, display_ctrl: 8'h0E, entry_mode: 8'h06,
              clear: 8'h01, home: 8'h02};
    cursor_addr = '0;

    // Hold reset low, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table under the reset codes
    for (int i = 0; i < OPENING_ROWS; i++) begin
      send_request(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);
    end

    // Random phases, codes rewritten only while idle
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      load_codes(settings[p]);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_request(random_request(), 1'b0, NO_STEP);
      end
    end

    wait_idle();
    if (fault_count == 0 && steps_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lcdns_pkg.sv
rtl/lcdns_if.sv
rtl/lcdns_front.sv
rtl/lcdns_queue.sv
rtl/lcdns_back.sv
rtl/char_lcd_nibble_sequencer_unit.sv
rtl/lcdns_checker.sv
tb/sv/tb.sv
